// ===== rtl/bvsoc_pkg.sv =====
package bvsoc_pkg;

    // Field and state widths.
    localparam int SAMPLE_W   = 13;
    localparam int SUM_W      = 20;
    localparam int CNT_W      = 8;
    localparam int RATIO_W    = 15;
    localparam int OFS_W      = 14;
    localparam int THR_W      = 15;
    localparam int REF_W      = 12;
    localparam int AVG_OUT_W  = 12;
    localparam int VOUT_W     = 16;
    localparam int SOC_W      = 10;
    localparam int LVL_W      = 3;
    localparam int HLTH_W     = 2;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = 15;
    localparam int SEG_NUM_W  = 24;
    localparam int MUL_CNT_W  = 4;

    // Converter reference voltage in millivolts.
    localparam logic [REF_W-1:0] REF_MV = 12'd3300;

    // Register reset values and the defaults taken by a threshold written as zero.
    localparam logic [CNT_W-1:0]   SPW_DEFAULT      = 8'd32;
    localparam logic [RATIO_W-1:0] RATIO_DEFAULT    = 15'd7055;
    localparam logic [THR_W-1:0]   FULL_DEFAULT     = 15'd14600;
    localparam logic [THR_W-1:0]   NOMINAL_DEFAULT  = 15'd12800;
    localparam logic [THR_W-1:0]   CUTOFF_DEFAULT   = 15'd10000;
    localparam logic [THR_W-1:0]   CRITICAL_DEFAULT = 15'd9000;

    // Fixed breakpoints of the charge curve.
    localparam logic [THR_W-1:0] BP_HIGH   = 15'd13600;
    localparam logic [THR_W-1:0] BP_UPPER  = 15'd13200;
    localparam logic [THR_W-1:0] BP_MID    = 15'd12000;
    localparam logic [THR_W-1:0] BP_LOW    = 15'd11000;
    localparam logic [THR_W-1:0] CHARGE_MV = 15'd13800;

    // State of charge at each breakpoint, in tenths of a percent.
    localparam logic [SOC_W-1:0] SOC_MAX     = 10'd1000;
    localparam logic [SOC_W-1:0] SOC_HIGH    = 10'd900;
    localparam logic [SOC_W-1:0] SOC_UPPER   = 10'd800;
    localparam logic [SOC_W-1:0] SOC_NOMINAL = 10'd500;
    localparam logic [SOC_W-1:0] SOC_MID     = 10'd200;
    localparam logic [SOC_W-1:0] SOC_LOW     = 10'd100;
    localparam logic [SOC_W-1:0] SOC_ZERO    = 10'd0;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_W-1:0] {
        REG_SPW      = 3'd0,
        REG_RATIO    = 3'd1,
        REG_OFFSET   = 3'd2,
        REG_FULL     = 3'd3,
        REG_NOMINAL  = 3'd4,
        REG_CUTOFF   = 3'd5,
        REG_CRITICAL = 3'd6
    } reg_idx_t;

    // Charge level classes.
    localparam logic [LVL_W-1:0] LVL_FULL     = 3'd0;
    localparam logic [LVL_W-1:0] LVL_GOOD     = 3'd1;
    localparam logic [LVL_W-1:0] LVL_MEDIUM   = 3'd2;
    localparam logic [LVL_W-1:0] LVL_LOW      = 3'd3;
    localparam logic [LVL_W-1:0] LVL_CRITICAL = 3'd4;

    // Health classes.
    localparam logic [HLTH_W-1:0] HLTH_GOOD     = 2'd0;
    localparam logic [HLTH_W-1:0] HLTH_LOW      = 2'd1;
    localparam logic [HLTH_W-1:0] HLTH_CRITICAL = 2'd2;
    localparam logic [HLTH_W-1:0] HLTH_FAULT    = 2'd3;

endpackage

// ===== rtl/bvsoc_div.sv =====
module bvsoc_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 22
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo,
    output logic [DEN_W-1:0] rem
);

    localparam int CW = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic             fits;
    logic [DEN_W-1:0] rem_next;
    logic [NUM_W-1:0] quo_next;

    // One restoring step: bring down the next numerator bit and try the divisor.
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[NUM_W-1]};
        diff     = {1'b0, shifted} - {2'b00, den_reg};
        fits     = !diff[DEN_W+1];
        rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        quo_next = {quo_reg[NUM_W-2:0], fits};
    end

    // Step sequencer: one quotient bit per cycle, most significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Shift registers for quotient and partial remainder.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

// ===== rtl/battery_voltage_soc_monitor_core.sv =====
// Channel   Direction  Beat contents                                   Handshake
// sample    in         sample, sample_ok                               sample_valid/ready
// result    out        adc_average, batt_mv, soc_tenths, charge_class, result_valid/ready
//                      health, charging
// config    in         cfg_index, cfg_data                             cfg_we
//
// A sample that does not close its window is taken, and the core stays ready for the next sample.
// The closing sample runs the shared 47-step divider for the average, a 15-step multiplier,
// the divider again for the voltage and, unless the voltage lies at or above the top of the
// curve or below its bottom, a third time for the segment; no sample is taken until the
// result register loads. A window with no valid sample skips all of these steps.
// A finished result sits in the output register; the next window is accepted
// while it waits, and a second result waits for the first to be taken.
// Reset clears the window and loads the register defaults.
module battery_voltage_soc_monitor_core #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic [bvsoc_pkg::SAMPLE_W-1:0]    sample,
    input  logic                              sample_ok,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [bvsoc_pkg::AVG_OUT_W-1:0]   adc_average,
    output logic signed [bvsoc_pkg::VOUT_W-1:0] batt_mv,
    output logic [bvsoc_pkg::SOC_W-1:0]       soc_tenths,
    output logic [bvsoc_pkg::LVL_W-1:0]       charge_class,
    output logic [bvsoc_pkg::HLTH_W-1:0]      health,
    output logic                              charging,
    input  logic                              cfg_we,
    input  logic [bvsoc_pkg::IDX_W-1:0]       cfg_index,
    input  logic [bvsoc_pkg::CFG_W-1:0]       cfg_data
);

    import bvsoc_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam logic [SAMPLE_BITS-1:0] ADC_MAX = '1;
    localparam int DEN_W = SAMPLE_BITS + 10;
    localparam logic [DEN_W-1:0] V_DEN = {ADC_MAX, 10'b0};
    localparam int MC_W  = SUM_W + REF_W;
    localparam int NUM_W = MC_W + RATIO_W;
    localparam int VR_W  = NUM_W - SAMPLE_BITS - 8;
    localparam int V_W   = VR_W + 2;

    typedef enum logic [2:0] {
        ST_ACC,
        ST_AVG,
        ST_MUL,
        ST_VDIV,
        ST_SEG,
        ST_SDIV,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        SEG_FULL,
        SEG_ZERO,
        SEG_INTERP
    } seg_mode_t;

    function automatic logic signed [V_W-1:0] ext_mv(input logic [THR_W-1:0] x);
        return $signed({{(V_W-THR_W){1'b0}}, x});
    endfunction

    // Configuration registers.
    logic [CNT_W-1:0]   spw_reg;
    logic [RATIO_W-1:0] ratio_reg;
    logic [OFS_W-1:0]   offset_reg;
    logic [THR_W-1:0]   full_reg;
    logic [THR_W-1:0]   nominal_reg;
    logic [THR_W-1:0]   cutoff_reg;
    logic [THR_W-1:0]   critical_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spw_reg      <= SPW_DEFAULT;
            ratio_reg    <= RATIO_DEFAULT;
            offset_reg   <= '0;
            full_reg     <= FULL_DEFAULT;
            nominal_reg  <= NOMINAL_DEFAULT;
            cutoff_reg   <= CUTOFF_DEFAULT;
            critical_reg <= CRITICAL_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_SPW:      spw_reg      <= cfg_data[CNT_W-1:0];
                REG_RATIO:    ratio_reg    <= cfg_data[RATIO_W-1:0];
                REG_OFFSET:   offset_reg   <= cfg_data[OFS_W-1:0];
                REG_FULL:     full_reg     <= cfg_data[THR_W-1:0];
                REG_NOMINAL:  nominal_reg  <= cfg_data[THR_W-1:0];
                REG_CUTOFF:   cutoff_reg   <= cfg_data[THR_W-1:0];
                REG_CRITICAL: critical_reg <= cfg_data[THR_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective window length and thresholds, zero meaning the default.
    logic [CNT_W-1:0] len_eff;
    logic [THR_W-1:0] full_eff;
    logic [THR_W-1:0] nominal_eff;
    logic [THR_W-1:0] cutoff_eff;
    logic [THR_W-1:0] critical_eff;

    assign len_eff      = (spw_reg == '0) ? SPW_DEFAULT : spw_reg;
    assign full_eff     = (full_reg == '0) ? FULL_DEFAULT : full_reg;
    assign nominal_eff  = (nominal_reg == '0) ? NOMINAL_DEFAULT : nominal_reg;
    assign cutoff_eff   = (cutoff_reg == '0) ? CUTOFF_DEFAULT : cutoff_reg;
    assign critical_eff = (critical_reg == '0) ? CRITICAL_DEFAULT : critical_reg;

    // Control and datapath registers.
    state_t               state_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]     vcnt_reg;
    logic [CNT_W-1:0]     win_reg;
    logic                 fault_reg;
    logic                 div_start_reg;
    logic [NUM_W-1:0]     div_num_reg;
    logic [DEN_W-1:0]     div_den_reg;
    logic [SUM_W-1:0]     avg_reg;
    logic [NUM_W-1:0]     mcand_reg;
    logic [RATIO_W-1:0]   mplier_reg;
    logic [NUM_W-1:0]     acc_reg;
    logic [MUL_CNT_W-1:0] mul_cnt_reg;
    logic signed [V_W-1:0] v_reg;
    logic [SOC_W-1:0]     soc_base_reg;
    logic [SOC_W-1:0]     soc_reg;
    logic                 result_valid_reg;
    logic [AVG_OUT_W-1:0] adc_average_reg;
    logic signed [VOUT_W-1:0] batt_mv_reg;
    logic [SOC_W-1:0]     soc_tenths_reg;
    logic [LVL_W-1:0]     charge_class_reg;
    logic [HLTH_W-1:0]    health_reg;
    logic                 charging_reg;

    // Shared divider.
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic [DEN_W-1:0] div_rem;

    bvsoc_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (div_num_reg),
        .den   (div_den_reg),
        .done  (div_done),
        .quo   (div_quo),
        .rem   (div_rem)
    );

    // Window accumulation for the incoming sample.
    logic             sample_fire;
    logic             sample_good;
    logic [SUM_W-1:0] sum_next;
    logic [CNT_W-1:0] vcnt_next;
    logic [CNT_W-1:0] win_next;
    logic             win_end;

    assign sample_ready = (state_reg == ST_ACC);
    assign sample_fire  = sample_valid && sample_ready;
    assign sample_good  = sample_ok && (CMP_W'(sample) <= CMP_W'(ADC_MAX));
    assign sum_next     = sample_good ? (sum_reg + SUM_W'(sample)) : sum_reg;
    assign vcnt_next    = sample_good ? (vcnt_reg + 1'b1) : vcnt_reg;
    assign win_next     = win_reg + 1'b1;
    assign win_end      = (win_next >= len_eff);

    // Serial multiplier step and voltage rounding.
    logic [NUM_W-1:0]        acc_add;
    logic                    mul_last;
    logic                    round_up;
    logic [VR_W-1:0]         v_round;
    logic signed [V_W-1:0]   v_next;

    assign acc_add  = mplier_reg[0] ? (acc_reg + mcand_reg) : acc_reg;
    assign mul_last = (mul_cnt_reg == MUL_CNT_W'(RATIO_W - 1));
    assign round_up = ({div_rem, 1'b0} >= {1'b0, V_DEN});
    assign v_round  = div_quo[VR_W-1:0] + VR_W'(round_up);
    assign v_next   = $signed({2'b00, v_round})
                    + $signed({{(V_W-OFS_W){offset_reg[OFS_W-1]}}, offset_reg});

    // Curve segment that holds the voltage.
    seg_mode_t            seg_mode;
    logic [THR_W-1:0]     seg_lo;
    logic [THR_W-1:0]     seg_hi;
    logic [SOC_W-1:0]     seg_tlo;
    logic                 seg_wide;
    logic [V_W-1:0]       seg_diff;
    logic [SEG_NUM_W-1:0] seg_num;

    always_comb
    begin
        seg_mode = SEG_INTERP;
        seg_lo   = BP_HIGH;
        seg_hi   = full_eff;
        seg_tlo  = SOC_HIGH;
        seg_wide = 1'b0;
        priority if (v_reg >= ext_mv(full_eff))
        begin
            seg_mode = SEG_FULL;
        end
        else if (v_reg >= ext_mv(BP_HIGH))
        begin
            seg_lo  = BP_HIGH;
            seg_hi  = full_eff;
            seg_tlo = SOC_HIGH;
        end
        else if (v_reg >= ext_mv(BP_UPPER))
        begin
            seg_lo  = BP_UPPER;
            seg_hi  = BP_HIGH;
            seg_tlo = SOC_UPPER;
        end
        else if (v_reg >= ext_mv(nominal_eff))
        begin
            seg_lo   = nominal_eff;
            seg_hi   = BP_UPPER;
            seg_tlo  = SOC_NOMINAL;
            seg_wide = 1'b1;
        end
        else if (v_reg >= ext_mv(BP_MID))
        begin
            seg_lo   = BP_MID;
            seg_hi   = nominal_eff;
            seg_tlo  = SOC_MID;
            seg_wide = 1'b1;
        end
        else if (v_reg >= ext_mv(BP_LOW))
        begin
            seg_lo  = BP_LOW;
            seg_hi  = BP_MID;
            seg_tlo = SOC_LOW;
        end
        else if (v_reg >= ext_mv(cutoff_eff))
        begin
            seg_lo  = cutoff_eff;
            seg_hi  = BP_LOW;
            seg_tlo = SOC_ZERO;
        end
        else
        begin
            seg_mode = SEG_ZERO;
        end
        // Inside a segment the offset from its low end stays below its span.
        seg_diff = v_reg - ext_mv(seg_lo);
        seg_num  = seg_wide ? (SEG_NUM_W'(seg_diff[THR_W-1:0]) * SEG_NUM_W'(300))
                            : (SEG_NUM_W'(seg_diff[THR_W-1:0]) * SEG_NUM_W'(100));
    end

    // Result classes and saturated voltage.
    logic [LVL_W-1:0]         lvl_next;
    logic [HLTH_W-1:0]        hlth_next;
    logic                     v_ovf;
    logic signed [VOUT_W-1:0] v_sat;

    always_comb
    begin
        priority if (soc_reg >= SOC_UPPER)
            lvl_next = LVL_FULL;
        else if (soc_reg >= SOC_NOMINAL)
            lvl_next = LVL_GOOD;
        else if (soc_reg >= SOC_MID)
            lvl_next = LVL_MEDIUM;
        else if (soc_reg >= SOC_LOW)
            lvl_next = LVL_LOW;
        else
            lvl_next = LVL_CRITICAL;

        priority if (v_reg < ext_mv(critical_eff))
            hlth_next = HLTH_CRITICAL;
        else if (v_reg < ext_mv(cutoff_eff))
            hlth_next = HLTH_LOW;
        else
            hlth_next = HLTH_GOOD;

        v_ovf = !((&v_reg[V_W-1:VOUT_W-1]) || !(|v_reg[V_W-1:VOUT_W-1]));
        if (v_ovf)
            v_sat = v_reg[V_W-1] ? {1'b1, {(VOUT_W-1){1'b0}}} : {1'b0, {(VOUT_W-1){1'b1}}};
        else
            v_sat = v_reg[VOUT_W-1:0];
    end

    // Divider launches and the output register load.
    logic out_load;
    logic div_start_next;

    assign out_load       = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);
    assign div_start_next = (sample_fire && win_end && (vcnt_next != '0))
                          || ((state_reg == ST_MUL) && mul_last)
                          || ((state_reg == ST_SEG) && (seg_mode == SEG_INTERP));

    // Sequencer: accumulate, then average, scale, round, interpolate inside the curve and publish.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_ACC;
            sum_reg          <= '0;
            vcnt_reg         <= '0;
            win_reg          <= '0;
            fault_reg        <= 1'b0;
            div_start_reg    <= 1'b0;
            mul_cnt_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            div_start_reg <= div_start_next;
            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && result_ready)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_ACC:
                begin
                    if (sample_fire)
                    begin
                        sum_reg  <= sum_next;
                        vcnt_reg <= vcnt_next;
                        win_reg  <= win_next;
                        if (win_end)
                        begin
                            if (vcnt_next == '0)
                            begin
                                fault_reg <= 1'b1;
                                state_reg <= ST_DONE;
                            end
                            else
                            begin
                                fault_reg   <= 1'b0;
                                div_num_reg <= NUM_W'(sum_next);
                                div_den_reg <= DEN_W'(vcnt_next);
                                state_reg   <= ST_AVG;
                            end
                        end
                    end
                end

                ST_AVG:
                begin
                    if (div_done)
                    begin
                        avg_reg     <= div_quo[SUM_W-1:0];
                        mcand_reg   <= NUM_W'(MC_W'(div_quo[SUM_W-1:0]) * MC_W'(REF_MV));
                        mplier_reg  <= ratio_reg;
                        acc_reg     <= '0;
                        mul_cnt_reg <= '0;
                        state_reg   <= ST_MUL;
                    end
                end

                ST_MUL:
                begin
                    acc_reg     <= acc_add;
                    mcand_reg   <= {mcand_reg[NUM_W-2:0], 1'b0};
                    mplier_reg  <= {1'b0, mplier_reg[RATIO_W-1:1]};
                    mul_cnt_reg <= mul_cnt_reg + 1'b1;
                    if (mul_last)
                    begin
                        div_num_reg <= acc_add;
                        div_den_reg <= V_DEN;
                        state_reg   <= ST_VDIV;
                    end
                end

                ST_VDIV:
                begin
                    if (div_done)
                    begin
                        v_reg     <= v_next;
                        state_reg <= ST_SEG;
                    end
                end

                ST_SEG:
                begin
                    unique case (seg_mode)
                        SEG_FULL:
                        begin
                            soc_reg   <= SOC_MAX;
                            state_reg <= ST_DONE;
                        end
                        SEG_ZERO:
                        begin
                            soc_reg   <= SOC_ZERO;
                            state_reg <= ST_DONE;
                        end
                        default:
                        begin
                            soc_base_reg <= seg_tlo;
                            div_num_reg  <= NUM_W'(seg_num);
                            div_den_reg  <= DEN_W'(seg_hi - seg_lo);
                            state_reg    <= ST_SDIV;
                        end
                    endcase
                end

                ST_SDIV:
                begin
                    if (div_done)
                    begin
                        soc_reg   <= soc_base_reg + div_quo[SOC_W-1:0];
                        state_reg <= ST_DONE;
                    end
                end

                ST_DONE:
                begin
                    if (out_load)
                    begin
                        if (fault_reg)
                        begin
                            adc_average_reg  <= '0;
                            batt_mv_reg      <= '0;
                            soc_tenths_reg   <= '0;
                            charge_class_reg <= '0;
                            health_reg       <= HLTH_FAULT;
                            charging_reg     <= 1'b0;
                        end
                        else
                        begin
                            adc_average_reg  <= avg_reg[AVG_OUT_W-1:0];
                            batt_mv_reg      <= v_sat;
                            soc_tenths_reg   <= soc_reg;
                            charge_class_reg <= lvl_next;
                            health_reg       <= hlth_next;
                            charging_reg     <= (v_reg > ext_mv(CHARGE_MV));
                        end
                        sum_reg   <= '0;
                        vcnt_reg  <= '0;
                        win_reg   <= '0;
                        state_reg <= ST_ACC;
                    end
                end

                default:
                begin
                    state_reg <= ST_ACC;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign adc_average  = adc_average_reg;
    assign batt_mv      = batt_mv_reg;
    assign soc_tenths   = soc_tenths_reg;
    assign charge_class = charge_class_reg;
    assign health       = health_reg;
    assign charging     = charging_reg;

    // A fault beat carries nothing but the fault code.
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && health == HLTH_FAULT) |->
            (adc_average == '0 && batt_mv == '0 && soc_tenths == '0
             && charge_class == '0 && !charging))
        else $error("fault beat carries non-zero fields");

    // The state of charge never leaves its range.
    a_soc_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (soc_tenths <= SOC_MAX))
        else $error("state of charge out of range");

    // A non-fault beat whose state of charge is at or above SOC_UPPER carries the full level class.
    a_level_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && health != HLTH_FAULT && soc_tenths >= SOC_UPPER)
            |-> (charge_class == LVL_FULL))
        else $error("level class disagrees with state of charge");

    // The divider only finishes while the sequencer waits for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_AVG || state_reg == ST_VDIV || state_reg == ST_SDIV))
        else $error("divider finished outside a waiting state");

endmodule
